### hdl/uer_pkg.sv
// Shared types, constants and codes of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 2'd2;

  localparam logic [7:0]  TRIG_TICKS_RST = 8'd10;
  localparam logic [7:0]  TICKS_PER_RST  = 8'd58;
  localparam logic [15:0] NEAR_LIMIT_RST = 16'd100;

  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_INC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  typedef struct packed {
    logic start_req;
    logic echo;
  } uer_in_t;

  typedef struct packed {
    logic        trigger;
    logic        done_res;
    logic [15:0] distance;
    logic        near;
    logic        busy_res;
  } uer_out_t;

  typedef struct packed {
    logic [1:0] cnt_op;
    logic       emit;
    logic       trig;
    logic       busy;
    logic       div_start;
  } uer_cmd_t;

  typedef struct packed {
    logic one_ge_len;
    logic inc_ge_len;
    logic div_fin;
    logic out_blocked;
  } uer_sts_t;

endpackage

### hdl/uer_ctrl.sv
// Measurement phase controller: input handshake and datapath commands.
module uer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uer_pkg::uer_in_t  in_data_i,
  input  uer_pkg::uer_sts_t sts_i,
  output uer_pkg::uer_cmd_t cmd_o
);
  import uer_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRIG  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  logic [2:0] st_q, st_d;
  logic       accept;

  assign in_stall_o = (st_q == ST_DIV) || sts_i.out_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          if (in_data_i.start_req) begin
            cmd_o.trig = 1'b1;
            cmd_o.busy = 1'b1;
            if (sts_i.one_ge_len) begin
              cmd_o.cnt_op = CNT_CLR;
              st_d         = ST_WAIT;
            end else begin
              cmd_o.cnt_op = CNT_ONE;
              st_d         = ST_TRIG;
            end
          end
        end
      end
      ST_TRIG: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          cmd_o.trig = 1'b1;
          cmd_o.busy = 1'b1;
          if (sts_i.inc_ge_len) begin
            cmd_o.cnt_op = CNT_CLR;
            st_d         = ST_WAIT;
          end else begin
            cmd_o.cnt_op = CNT_INC;
          end
        end
      end
      ST_WAIT: begin
        if (accept) begin
          cmd_o.emit = 1'b1;
          cmd_o.busy = 1'b1;
          if (in_data_i.echo) begin
            cmd_o.cnt_op = CNT_ONE;
            st_d         = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (accept) begin
          if (in_data_i.echo) begin
            cmd_o.emit   = 1'b1;
            cmd_o.busy   = 1'b1;
            cmd_o.cnt_op = CNT_INC;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.cnt_op    = CNT_CLR;
            st_d            = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_fin) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

### hdl/uer_dp.sv
// Ranger datapath: settings, tick counter, serial divider, result register.
module uer_dp #(
  parameter int unsigned COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  uer_pkg::uer_cmd_t                cmd_i,
  output uer_pkg::uer_sts_t                sts_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output uer_pkg::uer_out_t                out_data_o
);
  import uer_pkg::*;

  localparam int unsigned STEP_W = $clog2(COUNT_BITS + 1);
  localparam int unsigned QW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [7:0]  trig_ticks_q, ticks_per_q;
  logic [15:0] near_limit_q;

  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic [7:0]            trig_len;

  logic                  run_q, fin_q;
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_BITS-1:0] quo_q;
  logic [7:0]            rem_q;
  logic [8:0]            rem_sh, rem_sub;
  logic                  rem_ge;
  logic [QW-1:0]         quo_ext;
  logic [15:0]           quo_dist;

  logic [15:0] held_q;
  logic        out_valid_q;
  uer_out_t    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_TICKS_RST;
      ticks_per_q  <= TICKS_PER_RST;
      near_limit_q <= NEAR_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TRIG_TICKS: trig_ticks_q <= cfg_data_i[7:0];
        REG_TICKS_PER:  ticks_per_q  <= cfg_data_i[7:0];
        REG_NEAR_LIMIT: near_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign trig_len  = (trig_ticks_q == 8'd0) ? 8'd1 : trig_ticks_q;
  assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_ONE: count_d = COUNT_BITS'(1);
      CNT_INC: count_d = count_inc;
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[COUNT_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, ticks_per_q};
  assign rem_ge  = rem_sh >= {1'b0, ticks_per_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (cmd_i.div_start) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(COUNT_BITS);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= count_q;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[COUNT_BITS-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  assign quo_ext  = QW'(quo_q);
  assign quo_dist = ((ticks_per_q == 8'd0) || (quo_ext > QW'(16'hFFFF))) ?
                    16'hFFFF : quo_ext[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (fin_q) begin
      held_q <= quo_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_q || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      out_q.trigger  <= 1'b0;
      out_q.done_res <= 1'b1;
      out_q.distance <= quo_dist;
      out_q.near     <= quo_dist < near_limit_q;
      out_q.busy_res <= 1'b0;
    end else if (cmd_i.emit) begin
      out_q.trigger  <= cmd_i.trig;
      out_q.done_res <= 1'b0;
      out_q.distance <= held_q;
      out_q.near     <= held_q < near_limit_q;
      out_q.busy_res <= cmd_i.busy;
    end
  end

  assign sts_o.one_ge_len  = trig_len <= 8'd1;
  assign sts_o.inc_ge_len  = count_inc >= COUNT_BITS'(trig_len);
  assign sts_o.div_fin     = fin_q;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: phase controller and datapath.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall  | start_req, echo (one tick)
//   out     | output    | out_valid/out_stall| trigger, done_res, distance, near, busy_res
//   cfg     | input     | cfg_valid/cfg_ready| register index, write data
//
// The tick that ends an echo pulse starts the bit-serial divider, and no
// further tick is taken until the divider has finished.
// The next tick is taken while a result waits, unless the result is stalled.
// Reset restores the register defaults and returns the phase to idle.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  uer_pkg::uer_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output uer_pkg::uer_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import uer_pkg::*;

  uer_cmd_t cmd;
  uer_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uer_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for the ultrasonic echo ranger: tick stimulus, prediction, result checks.
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int unsigned CB = COUNT_BITS_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 20;

  class echo_range_tracker;
    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_COUNT} phase_e;

    logic [7:0]    trig_ticks;
    logic [7:0]    ticks_per_unit;
    logic [15:0]   near_limit;
    phase_e        phase;
    logic [CB-1:0] count;
    logic [15:0]   held;
    uer_out_t      expected_beats[$];
    int            errors;
    int            done_seen;

    function new();
      trig_ticks     = TRIG_TICKS_RST;
      ticks_per_unit = TICKS_PER_RST;
      near_limit     = NEAR_LIMIT_RST;
      phase          = PH_IDLE;
      count          = '0;
      held           = '0;
      errors         = 0;
      done_seen      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TRIG_TICKS: trig_ticks = data[7:0];
        REG_TICKS_PER: ticks_per_unit = data[7:0];
        REG_NEAR_LIMIT: near_limit = data[15:0];
        default: ;
      endcase
    endfunction

    // one tick in, one predicted beat out
    function void note_tick(uer_in_t t);
      uer_out_t          o;
      logic [7:0]        len;
      longint unsigned   q;
      o = '0;
      len = (trig_ticks == 8'd0) ? 8'd1 : trig_ticks;
      case (phase)
        PH_IDLE: if (t.start_req) begin
          o.trigger = 1'b1;
          if (len == 8'd1) begin
            count = '0;
            phase = PH_WAIT;
          end else begin
            count = CB'(1);
            phase = PH_TRIG;
          end
        end
        PH_TRIG: begin
          o.trigger = 1'b1;
          if (count != '1) count = count + 1'b1;
          if (count >= len) begin
            count = '0;
            phase = PH_WAIT;
          end
        end
        PH_WAIT: if (t.echo) begin
          count = CB'(1);
          phase = PH_COUNT;
        end
        default: if (t.echo) begin
          if (count != '1) count = count + 1'b1;
        end else begin
          if (ticks_per_unit == 8'd0) begin
            held = 16'hFFFF;
          end else begin
            q = longint'(count) / longint'(ticks_per_unit);
            held = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
          end
          o.done_res = 1'b1;
          count = '0;
          phase = PH_IDLE;
        end
      endcase
      o.distance = held;
      o.near     = (held < near_limit);
      o.busy_res = (phase != PH_IDLE);
      expected_beats.push_back(o);
    endfunction

    function void field_err(string name, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    endfunction

    function void check_beat(uer_out_t got);
      uer_out_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        return;
      end
      want = expected_beats.pop_front();
      if (want.done_res) done_seen++;
      if (got.trigger !== want.trigger)
        field_err("trigger", 16'(want.trigger), 16'(got.trigger));
      if (got.done_res !== want.done_res)
        field_err("done_res", 16'(want.done_res), 16'(got.done_res));
      if (got.distance !== want.distance) field_err("distance", want.distance, got.distance);
      if (got.near !== want.near) field_err("near", 16'(want.near), 16'(got.near));
      if (got.busy_res !== want.busy_res)
        field_err("busy_res", 16'(want.busy_res), 16'(got.busy_res));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  uer_in_t               in_data = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  uer_out_t              out_data_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  echo_range_tracker tracker = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int ticks_sent = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall_o === 1'b0) begin
        tracker.note_tick(in_data);
        quiet_cycles = 0;
      end else if (out_valid_o === 1'b1 && !out_stall) begin
        quiet_cycles = 0;
      end else if (cfg_valid && cfg_ready_o === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o === 1'b1 && !out_stall) tracker.check_beat(out_data_o);
      if (cfg_valid && cfg_ready_o === 1'b1) begin
        tracker.write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data.start_req <= start;
    in_data.echo <= echo;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_beats.size() != 0);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
  endtask

  task automatic set_config(input logic [15:0] trig, input logic [15:0] per,
                            input logic [15:0] lim);
    drain_results();
    repeat (4) @(posedge clk);
    write_one(REG_TRIG_TICKS, trig);
    write_one(REG_TICKS_PER, per);
    write_one(REG_NEAR_LIMIT, lim);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // start, trigger ticks, echo low wait, echo high pulse, falling edge
  task automatic run_measurement(input int wait_len, input int echo_len);
    int len;
    len = (tracker.trig_ticks == 8'd0) ? 1 : tracker.trig_ticks;
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (len - 1) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (wait_len) send_tick(1'($urandom_range(1)), 1'b0);
    repeat (echo_len) send_tick(1'($urandom_range(1)), 1'b1);
    send_tick(1'($urandom_range(1)), 1'b0);
  endtask

  task automatic random_phase(input int n_items);
    int first;
    first = ticks_sent;
    while (ticks_sent - first < n_items) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(9) == 0) run_measurement($urandom_range(8), $urandom_range(60, 200));
        else run_measurement($urandom_range(3), $urandom_range(0, 40));
      end else begin
        repeat ($urandom_range(1, 6))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: near after reset, start and echo ignored while triggering
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    for (int k = 0; k < 9; k++) send_tick(1'b1, k[0]);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (116) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);

    // zero trigger length, zero divisor, zero near limit
    set_config(16'h0000, 16'h0000, 16'h0000);
    run_measurement(1, 3);
    run_measurement(0, 1);

    // upper data bits dropped on 8-bit registers
    set_config(16'hFF01, 16'hFF01, 16'hFFFF);
    run_measurement(0, 1);

    set_config(16'd255, 16'd255, 16'h8000);
    run_measurement(2, 60);

    for (int m = 0; m < 8; m++) begin
      case (m % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 53; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 53; end
        default: begin send_idle = 53; recv_stall = 53; end
      endcase
      set_config(16'($urandom_range(1, 12)),
                 16'((m % 3 == 0) ? $urandom_range(1, 8) : $urandom_range(1, 255)),
                 16'((m % 2 == 1) ? $urandom_range(0, 65535) : $urandom_range(0, 40)));
      if (m == 0) hold_left <= 400;
      if (m == 4) begin
        random_phase(25);
        drain_results();
        random_phase(25);
      end else begin
        random_phase(50);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Drove %0d ticks, checked %0d completed measurements, %0d register writes.",
             ticks_sent, tracker.done_seen, reg_writes);
    $display("Covered zero and full-scale trigger and divisor, long output hold-off, stalls.");
    if (tracker.errors == 0 && tracker.expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d beats still expected", tracker.errors,
               tracker.expected_beats.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
